// File: rtl/core/potmr_pkg.sv
// ----------------------------------------------------------------------------
// potmr_pkg
// Shared types and constants for the periodic / one-shot timer table.
// ----------------------------------------------------------------------------
package potmr_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int TIME_W = 32;
   localparam int IVAL_W = 31;
   localparam int ID_W   = 16;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic KIND_PERIODIC = 1'b0;
   localparam logic KIND_ONESHOT  = 1'b1;

   localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
   localparam logic [ID_W-1:0] ID_MAX   = 16'hFFFF;

   typedef struct packed {
      logic              kind;
      logic [IVAL_W-1:0] interval;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] fire_time;
      logic [ID_W-1:0]   id;
      logic              armed;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [TIME_W-1:0] diff;
      logic              ge;
      logic              eq;
   } alu_res_type;

endpackage

// File: rtl/core/potmr_ram.sv
// ----------------------------------------------------------------------------
// potmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module potmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/potmr_alu.sv
// ----------------------------------------------------------------------------
// potmr_alu
// Shared 32-bit subtract / compare unit: difference, a >= b, a == b.
// ----------------------------------------------------------------------------
module potmr_alu (
   input  logic [potmr_pkg::TIME_W-1:0] op_a,
   input  logic [potmr_pkg::TIME_W-1:0] op_b,
   output potmr_pkg::alu_res_type       res
);

   logic [potmr_pkg::TIME_W:0] sum;

   assign sum      = {1'b0, op_a} + {1'b0, ~op_b} + {{potmr_pkg::TIME_W{1'b0}}, 1'b1};
   assign res.diff = sum[potmr_pkg::TIME_W-1:0];
   assign res.ge   = sum[potmr_pkg::TIME_W];
   assign res.eq   = (sum[potmr_pkg::TIME_W-1:0] == '0);

endmodule

// File: rtl/core/periodic_oneshot_timer_table_unit.sv
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_table_unit
// Timer table: add, remove by identifier, and tick scan with firing reports.
// ----------------------------------------------------------------------------
// Sequence: an add passes S_ADD then S_RESP; a full-table add or unused command goes
//   straight to S_RESP. Tick and remove read then compare each entry, comparing twice
//   for an armed periodic one, plus a push per firing, a read and write per swap with
//   last, and an end-of-table check before S_RESP that a remove hit skips.
// Requests: one at a time; the next is taken the cycle after the final response loads.
// Reset: entry count 0, next identifier 1; table RAM contents are not cleared.
module periodic_oneshot_timer_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [potmr_pkg::TIME_W-1:0]        req_now_time,
   input  logic                                req_entry_kind,
   input  logic [potmr_pkg::IVAL_W-1:0]        req_interval,
   input  logic [potmr_pkg::TIME_W-1:0]        req_deadline,
   input  logic [potmr_pkg::ID_W-1:0]          req_target_id,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_fired,
   output logic [potmr_pkg::ID_W-1:0]          rsp_entry_id,
   output logic                                rsp_last
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ADD     = 4'd1;
   localparam logic [3:0] S_RESP    = 4'd2;
   localparam logic [3:0] S_READ    = 4'd3;
   localparam logic [3:0] S_EVAL    = 4'd4;
   localparam logic [3:0] S_CMP     = 4'd5;
   localparam logic [3:0] S_PUSH    = 4'd6;
   localparam logic [3:0] S_MOVE_RD = 4'd7;
   localparam logic [3:0] S_MOVE_WR = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [potmr_pkg::CNT_W-1:0] count_ff, count_in;
   logic [potmr_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [potmr_pkg::CNT_W-1:0] count_dec;
   logic [potmr_pkg::ID_W-1:0]  next_id_ff, next_id_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [potmr_pkg::ID_W-1:0]  pend_id_ff, pend_id_in;
   logic                        drop_ff, drop_in;
   logic [potmr_pkg::TIME_W-1:0] diff_ff, diff_in;

   logic [1:0]                   cmd_ff, cmd_in;
   logic [potmr_pkg::TIME_W-1:0] now_ff, now_in;
   logic                         kind_ff, kind_in;
   logic [potmr_pkg::IVAL_W-1:0] ival_ff, ival_in;
   logic [potmr_pkg::TIME_W-1:0] dl_ff, dl_in;
   logic [potmr_pkg::ID_W-1:0]   tgt_ff, tgt_in;

   logic [1:0]                  res_status_ff, res_status_in;
   logic                        res_fired_ff, res_fired_in;
   logic [potmr_pkg::ID_W-1:0]  res_id_ff, res_id_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic                        rsp_fired_ff, rsp_fired_in;
   logic [potmr_pkg::ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                         out_free;
   logic                         load_push;
   logic                         load_resp;

   logic                         ram_we;
   logic [potmr_pkg::IDX_W-1:0]  ram_wr_addr;
   potmr_pkg::entry_type         ram_wr_entry;
   logic                         ram_re;
   logic [potmr_pkg::IDX_W-1:0]  ram_rd_addr;
   logic [potmr_pkg::ENTRY_W-1:0] ram_rd_data;
   potmr_pkg::entry_type         entry;
   potmr_pkg::entry_type         fire_entry;
   potmr_pkg::entry_type         add_entry;

   logic [potmr_pkg::TIME_W-1:0] alu_a, alu_b;
   potmr_pkg::alu_res_type       alu_res;

   potmr_ram #(
      .WIDTH (potmr_pkg::ENTRY_W),
      .DEPTH (potmr_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   potmr_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   assign entry     = ram_rd_data;
   assign count_dec = count_ff - 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      fire_entry           = entry;
      fire_entry.fire_time = now_ff;
      fire_entry.armed     = 1'b1;

      add_entry.kind      = kind_ff;
      add_entry.interval  = ival_ff;
      add_entry.deadline  = dl_ff;
      add_entry.fire_time = '0;
      add_entry.id        = next_id_ff;
      add_entry.armed     = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      next_id_in    = next_id_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      drop_in       = drop_ff;
      diff_in       = diff_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      kind_in       = kind_ff;
      ival_in       = ival_ff;
      dl_in         = dl_ff;
      tgt_in        = tgt_ff;
      res_status_in = res_status_ff;
      res_fired_in  = res_fired_ff;
      res_id_in     = res_id_ff;
      load_push     = 1'b0;
      load_resp     = 1'b0;
      ram_we        = 1'b0;
      ram_wr_addr   = idx_ff[potmr_pkg::IDX_W-1:0];
      ram_wr_entry  = fire_entry;
      ram_re        = 1'b0;
      ram_rd_addr   = idx_ff[potmr_pkg::IDX_W-1:0];
      alu_a         = now_ff;
      alu_b         = entry.fire_time;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               now_in        = req_now_time;
               kind_in       = req_entry_kind;
               ival_in       = req_interval;
               dl_in         = req_deadline;
               tgt_in        = req_target_id;
               pend_valid_in = 1'b0;
               drop_in       = 1'b0;
               idx_in        = '0;
               res_status_in = potmr_pkg::STATUS_OK;
               res_fired_in  = 1'b0;
               res_id_in     = '0;
               case (req_command)
                  potmr_pkg::CMD_TICK,
                  potmr_pkg::CMD_REMOVE: begin
                     state_in = S_READ;
                  end
                  potmr_pkg::CMD_ADD: begin
                     if (count_ff == potmr_pkg::CNT_W'(potmr_pkg::TABLE_DEPTH)) begin
                        res_status_in = potmr_pkg::STATUS_FULL;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_ADD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_ADD: begin
            ram_we       = 1'b1;
            ram_wr_addr  = count_ff[potmr_pkg::IDX_W-1:0];
            ram_wr_entry = add_entry;
            res_id_in    = next_id_ff;
            next_id_in   = (next_id_ff == potmr_pkg::ID_MAX) ? potmr_pkg::ID_FIRST
                                                             : next_id_ff + 1'b1;
            count_in     = count_ff + 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               load_resp = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_READ: begin
            if (idx_ff < count_ff) begin
               ram_re   = 1'b1;
               state_in = S_EVAL;
            end else if (cmd_ff == potmr_pkg::CMD_TICK) begin
               res_status_in = potmr_pkg::STATUS_OK;
               res_fired_in  = pend_valid_ff;
               res_id_in     = pend_valid_ff ? pend_id_ff : '0;
               pend_valid_in = 1'b0;
               state_in      = S_RESP;
            end else begin
               res_status_in = potmr_pkg::STATUS_NOT_FOUND;
               res_id_in     = tgt_ff;
               state_in      = S_RESP;
            end
         end
         S_EVAL: begin
            if (cmd_ff == potmr_pkg::CMD_REMOVE) begin
               alu_a = {{(potmr_pkg::TIME_W - potmr_pkg::ID_W){1'b0}}, tgt_ff};
               alu_b = {{(potmr_pkg::TIME_W - potmr_pkg::ID_W){1'b0}}, entry.id};
               if (alu_res.eq) begin
                  state_in = S_MOVE_RD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end else if (entry.kind == potmr_pkg::KIND_ONESHOT) begin
               alu_a = now_ff;
               alu_b = entry.deadline;
               if (alu_res.ge) begin
                  drop_in  = 1'b1;
                  state_in = S_PUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end else if (!entry.armed) begin
               ram_we   = 1'b1;
               drop_in  = 1'b0;
               state_in = S_PUSH;
            end else begin
               alu_a    = now_ff;
               alu_b    = entry.fire_time;
               diff_in  = alu_res.diff;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            alu_a = diff_ff;
            alu_b = {1'b0, entry.interval};
            if (alu_res.ge) begin
               ram_we   = 1'b1;
               drop_in  = 1'b0;
               state_in = S_PUSH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_PUSH: begin
            // older firing goes out first; the newest waits to learn if it is last
            if (!pend_valid_ff || out_free) begin
               load_push     = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_id_in    = entry.id;
               if (drop_ff) begin
                  state_in = S_MOVE_RD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_MOVE_RD: begin
            count_in    = count_dec;
            ram_re      = 1'b1;
            ram_rd_addr = count_dec[potmr_pkg::IDX_W-1:0];
            state_in    = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            ram_we       = 1'b1;
            ram_wr_entry = entry;
            drop_in      = 1'b0;
            if (cmd_ff == potmr_pkg::CMD_REMOVE) begin
               res_status_in = potmr_pkg::STATUS_OK;
               res_id_in     = tgt_ff;
               state_in      = S_RESP;
            end else begin
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_push) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = potmr_pkg::STATUS_OK;
         rsp_fired_in  = 1'b1;
         rsp_id_in     = pend_id_ff;
         rsp_last_in   = 1'b0;
      end else if (load_resp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_fired_in  = res_fired_ff;
         rsp_id_in     = res_id_ff;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         next_id_ff    <= potmr_pkg::ID_FIRST;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_id_ff    <= next_id_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pend_id_ff    <= pend_id_in;
      drop_ff       <= drop_in;
      diff_ff       <= diff_in;
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      kind_ff       <= kind_in;
      ival_ff       <= ival_in;
      dl_ff         <= dl_in;
      tgt_ff        <= tgt_in;
      res_status_ff <= res_status_in;
      res_fired_ff  <= res_fired_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_fired    = rsp_fired_ff;
   assign rsp_entry_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: sim/timer_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_table_checker
// Watches the request and response channels of the timer table, keeps its own
// copy of the table and the identifier counter, and compares every response,
// field by field, with the oldest predicted report.
// ----------------------------------------------------------------------------
module timer_table_checker
   import potmr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [TIME_W-1:0] req_now_time,
   input  logic              req_entry_kind,
   input  logic [IVAL_W-1:0] req_interval,
   input  logic [TIME_W-1:0] req_deadline,
   input  logic [ID_W-1:0]   req_target_id,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [1:0]        rsp_status,
   input  logic              rsp_fired,
   input  logic [ID_W-1:0]   rsp_entry_id,
   input  logic              rsp_last,
   output int                error_count,
   output int                pending,
   output int                table_count
);

   typedef struct packed {
      logic [1:0]      status;
      logic            fired;
      logic [ID_W-1:0] entry_id;
      logic            last;
   } report_type;

   entry_type       timers [TABLE_DEPTH];
   int              timer_count;
   logic [ID_W-1:0] id_next;
   report_type      report_q [$];

   function automatic report_type make_report(logic [1:0] status, logic fired,
                                              logic [ID_W-1:0] entry_id, logic last);
      report_type r;
      r.status   = status;
      r.fired    = fired;
      r.entry_id = entry_id;
      r.last     = last;
      return r;
   endfunction

   // swap-with-last: the final entry fills the freed slot
   task automatic drop_timer(int slot);
      timer_count--;
      timers[slot] = timers[timer_count];
   endtask

   task automatic scan_timers(logic [TIME_W-1:0] now);
      int                slot;
      logic              fire;
      logic              drop;
      logic              held;
      logic [ID_W-1:0]   held_id;
      logic [TIME_W-1:0] gap;
      slot    = 0;
      held    = 1'b0;
      held_id = '0;
      while (slot < timer_count) begin
         fire = 1'b0;
         drop = 1'b0;
         if (timers[slot].kind == KIND_PERIODIC) begin
            gap = now - timers[slot].fire_time;
            if (!timers[slot].armed || gap >= {1'b0, timers[slot].interval}) begin
               fire                   = 1'b1;
               timers[slot].fire_time = now;
               timers[slot].armed     = 1'b1;
            end
         end else if (now >= timers[slot].deadline) begin
            fire = 1'b1;
            drop = 1'b1;
         end
         if (fire) begin
            // a report is pushed once the next one shows it was not the last
            if (held)
               report_q.push_back(make_report(STATUS_OK, 1'b1, held_id, 1'b0));
            held    = 1'b1;
            held_id = timers[slot].id;
         end
         // a moved-in entry is checked again in the same slot
         if (drop)
            drop_timer(slot);
         else
            slot++;
      end
      if (held)
         report_q.push_back(make_report(STATUS_OK, 1'b1, held_id, 1'b1));
      else
         report_q.push_back(make_report(STATUS_OK, 1'b0, '0, 1'b1));
   endtask

   task automatic add_timer();
      logic [ID_W-1:0] id;
      if (timer_count >= TABLE_DEPTH) begin
         report_q.push_back(make_report(STATUS_FULL, 1'b0, '0, 1'b1));
      end else begin
         id      = id_next;
         id_next = (id == ID_MAX) ? ID_FIRST : id + 1'b1;
         timers[timer_count].kind      = req_entry_kind;
         timers[timer_count].interval  = req_interval;
         timers[timer_count].deadline  = req_deadline;
         timers[timer_count].fire_time = '0;
         timers[timer_count].id        = id;
         timers[timer_count].armed     = 1'b0;
         timer_count++;
         report_q.push_back(make_report(STATUS_OK, 1'b0, id, 1'b1));
      end
   endtask

   task automatic remove_timer();
      int   slot;
      logic found;
      found = 1'b0;
      for (slot = 0; slot < timer_count && !found; slot++) begin
         if (timers[slot].id == req_target_id) begin
            drop_timer(slot);
            found = 1'b1;
         end
      end
      report_q.push_back(make_report(found ? STATUS_OK : STATUS_NOT_FOUND, 1'b0,
                                     req_target_id, 1'b1));
   endtask

   task automatic compare_field(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   task automatic check_report();
      report_type want;
      if (report_q.size() == 0) begin
         $error("unexpected response: status %0d fired %0b entry_id %0d last %0b",
                rsp_status, rsp_fired, rsp_entry_id, rsp_last);
         error_count++;
      end else begin
         want = report_q.pop_front();
         compare_field("status", want.status, rsp_status);
         compare_field("fired", want.fired, rsp_fired);
         compare_field("entry_id", want.entry_id, rsp_entry_id);
         compare_field("last", want.last, rsp_last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timer_count = 0;
         id_next     = ID_FIRST;
         report_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_report();
         if (req_valid && !req_stall) begin
            case (req_command)
               CMD_TICK:   scan_timers(req_now_time);
               CMD_ADD:    add_timer();
               CMD_REMOVE: remove_timer();
               default:    report_q.push_back(make_report(STATUS_OK, 1'b0, '0, 1'b1));
            endcase
         end
      end
      pending     = report_q.size();
      table_count = timer_count;
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the periodic / one-shot timer table: directed corner requests,
// a fill past full with a one-shot flush, then random traffic under several
// idle and stall mixes, with a long response hold-off. Checking is done by
// timer_table_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import potmr_pkg::*;

   localparam logic [1:0] CMD_UNUSED      = 2'd3;
   localparam int         QUIET_LIMIT     = 5000;
   localparam int         HOLD_OFF_CYCLES = 300;
   localparam int         ITEMS_PER_PHASE = 80;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_command;
   logic [TIME_W-1:0] req_now_time;
   logic              req_entry_kind;
   logic [IVAL_W-1:0] req_interval;
   logic [TIME_W-1:0] req_deadline;
   logic [ID_W-1:0]   req_target_id;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_status;
   logic              rsp_fired;
   logic [ID_W-1:0]   rsp_entry_id;
   logic              rsp_last;

   int                error_count;
   int                pending;
   int                table_count;
   int                send_idle_pct;
   int                recv_stall_pct;
   int                hold_left;
   int                quiet_cycles;
   logic [TIME_W-1:0] time_now;
   logic [ID_W-1:0]   known_ids [$];

   periodic_oneshot_timer_table_unit dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_command,
      .req_now_time,
      .req_entry_kind,
      .req_interval,
      .req_deadline,
      .req_target_id,
      .rsp_valid,
      .rsp_stall,
      .rsp_status,
      .rsp_fired,
      .rsp_entry_id,
      .rsp_last
   );

   timer_table_checker checker_inst (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_command,
      .req_now_time,
      .req_entry_kind,
      .req_interval,
      .req_deadline,
      .req_target_id,
      .rsp_valid,
      .rsp_stall,
      .rsp_status,
      .rsp_fired,
      .rsp_entry_id,
      .rsp_last,
      .error_count,
      .pending,
      .table_count
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
      end
   end

   // identifiers handed out, kept as remove targets
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !rsp_fired && rsp_status == STATUS_OK &&
          rsp_entry_id != '0) begin
         known_ids.push_back(rsp_entry_id);
         if (known_ids.size() > 48)
            known_ids.pop_front();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] command, input logic [TIME_W-1:0] now_time,
                               input logic kind, input logic [IVAL_W-1:0] interval,
                               input logic [TIME_W-1:0] deadline,
                               input logic [ID_W-1:0] target_id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_command    = command;
      req_now_time   = now_time;
      req_entry_kind = kind;
      req_interval   = interval;
      req_deadline   = deadline;
      req_target_id  = target_id;
      req_valid      = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_request();
      int                pick;
      int                add_pct;
      logic [1:0]        command;
      logic [TIME_W-1:0] now_time;
      logic [TIME_W-1:0] deadline;
      logic [IVAL_W-1:0] interval;
      logic [ID_W-1:0]   target_id;
      logic              kind;
      add_pct   = (table_count < 4) ? 60 : (table_count > 28) ? 15 : 35;
      pick      = $urandom_range(99);
      now_time  = $urandom;
      kind      = 1'($urandom);
      interval  = IVAL_W'($urandom);
      deadline  = $urandom;
      target_id = ID_W'($urandom);
      if (pick < add_pct) begin
         command = CMD_ADD;
         if ($urandom_range(9) != 0) begin
            interval = IVAL_W'($urandom_range(40));
            deadline = time_now + $urandom_range(60);
         end
      end else if (pick < add_pct + (95 - add_pct) / 2) begin
         command = CMD_TICK;
         if ($urandom_range(14) == 0)
            time_now = $urandom;
         else
            time_now += $urandom_range(15);
         now_time = time_now;
      end else if (pick < 95) begin
         command = CMD_REMOVE;
         if (known_ids.size() != 0 && $urandom_range(9) < 7)
            target_id = known_ids[$urandom_range(known_ids.size() - 1)];
      end else begin
         command = CMD_UNUSED;
      end
      send_request(command, now_time, kind, interval, deadline, target_id);
   endtask

   initial begin
      int phase;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_TICK;
      req_now_time   = '0;
      req_entry_kind = KIND_PERIODIC;
      req_interval   = '0;
      req_deadline   = '0;
      req_target_id  = '0;
      rsp_stall      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      quiet_cycles   = 0;
      time_now       = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(CMD_TICK, '0, KIND_PERIODIC, '0, '0, '0);
      send_request(CMD_REMOVE, '0, KIND_PERIODIC, '0, '0, ID_MAX);
      send_request(CMD_UNUSED, '1, KIND_ONESHOT, '1, '1, '1);
      send_request(CMD_ADD, '0, KIND_PERIODIC, '0, '0, '0);
      send_request(CMD_ADD, '0, KIND_PERIODIC, '1, '0, '0);
      send_request(CMD_ADD, '0, KIND_ONESHOT, '0, '1, '0);
      send_request(CMD_ADD, '0, KIND_ONESHOT, '0, '0, '0);
      send_request(CMD_ADD, '0, KIND_PERIODIC, 31'd5, '0, '0);
      // first firings; the due one-shot is swapped out and the moved entry fires
      send_request(CMD_TICK, 32'd0, KIND_PERIODIC, '0, '0, '0);
      send_request(CMD_TICK, 32'd3, KIND_PERIODIC, '0, '0, '0);
      send_request(CMD_TICK, '1, KIND_PERIODIC, '0, '0, '0);
      // time wrapped past zero
      send_request(CMD_TICK, 32'd2, KIND_PERIODIC, '0, '0, '0);
      send_request(CMD_REMOVE, '0, KIND_PERIODIC, '0, '0, 16'd2);
      send_request(CMD_REMOVE, '0, KIND_PERIODIC, '0, '0, 16'd2);
      send_request(CMD_REMOVE, '0, KIND_PERIODIC, '0, '0, 16'd0);

      // fill, overfill and flush one-shots
      repeat (TABLE_DEPTH - table_count + 1)
         send_request(CMD_ADD, $urandom, KIND_ONESHOT, IVAL_W'($urandom),
                      $urandom_range(1000), ID_W'($urandom));
      send_request(CMD_TICK, '1, KIND_PERIODIC, '0, '0, '0);
      time_now = $urandom;

      for (phase = 0; phase < 4; phase++) begin
         req_valid = 1'b0;
         wait (pending == 0);
         @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               hold_left      = HOLD_OFF_CYCLES;
            end
            1: begin
               send_idle_pct  = 48;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 48;
            end
            default: begin
               send_idle_pct  = 25;
               recv_stall_pct = 25;
            end
         endcase
         repeat (ITEMS_PER_PHASE)
            send_random_request();
      end

      req_valid = 1'b0;
      wait (pending == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/potmr_pkg.sv
rtl/core/potmr_ram.sv
rtl/core/potmr_alu.sv
rtl/core/periodic_oneshot_timer_table_unit.sv
sim/timer_table_checker.sv
sim/tb_top.sv
